@@ rtl/scdc_pkg.sv @@
package scdc_pkg;

    localparam logic [12:0] QONE          = 13'd4096;
    localparam logic [14:0] MIN_RANGE     = 15'd10;
    localparam logic [12:0] THROTTLE_STEP = 13'd205;
    localparam logic [12:0] BRAKE_STEP    = 13'd410;
    localparam logic [12:0] STEER_STEP    = 13'd205;
    localparam logic signed [15:0] GEAR_SWITCH_STOP_SPEED = 16'sd50;
    // fs * 10 < -36 holds exactly for fs <= -4
    localparam logic signed [15:0] ROLLBACK_LIMIT = -16'sd3;
    localparam int unsigned DIV_BITS = 12;

    typedef enum logic [1:0] {
        CMD_MOVE    = 2'd0,
        CMD_PARK    = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_SPARE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_MAX_SPEED      = 3'd0,
        REG_SLOWDOWN_RANGE = 3'd1,
        REG_SPEED_TOL      = 3'd2,
        REG_LIMIT_BRAKE    = 3'd3,
        REG_STOP_BRAKE     = 3'd4,
        REG_ACCEL_STEP     = 3'd5,
        REG_DECEL_STEP     = 3'd6,
        REG_HB_ON_BRAKE    = 3'd7
    } t_reg;

    // move cur toward tgt by at most step; zero step jumps
    function automatic logic signed [17:0] slew18(
        input logic signed [17:0] cur,
        input logic signed [17:0] tgt,
        input logic signed [17:0] step
    );
        logic signed [17:0] d;
        logic signed [17:0] r;
        begin
            d = tgt - cur;
            if (step == 18'sd0) begin
                r = tgt;
            end else if (d > step) begin
                r = cur + step;
            end else if (d < -step) begin
                r = cur - step;
            end else begin
                r = tgt;
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/speed_command_drive_controller_unit.sv @@
// Forward-only drive controller, one result per control tick. A tick is
// taken when i_valid and o_ready meet; o_ready stays low until its result
// has been taken. A move tick runs through the accept state, a setup state,
// two 12-step restoring divisions (speed error over slowdown range, and
// headroom to max speed over slowdown range) sharing one divider, a
// multiply state, a state that adds braking and slews the actuators, and
// a state with the result offered. Stop and backward-roll ticks go from the
// setup state straight to the result. Registers are written through the
// configuration channel, which is always ready; the user must write them
// only while no tick is open, as the block itself does not enforce this.
module speed_command_drive_controller_unit
    import scdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_target_speed,
    input  logic signed [13:0] i_brake_request,
    input  logic               i_brake_flag,
    input  logic signed [13:0] i_steer_request,
    input  logic signed [15:0] i_forward_speed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [12:0]        o_throttle_out,
    output logic [12:0]        o_brake_out,
    output logic signed [13:0] o_steering_out,
    output logic               o_handbrake_out,
    output logic [14:0]        o_slewed_speed_out
);

    typedef enum logic [2:0] {S_IDLE, S_PRE, S_DIV, S_MUL, S_FIN, S_OUT} t_state;

    t_state r_state;

    logic [14:0] r_max_speed, r_range_reg, r_tol, r_accel, r_decel;
    logic [12:0] r_limit_brake, r_stop_brake;
    logic        r_hb_on_brake;

    logic [1:0]         r_cmd;
    logic signed [15:0] r_ts;
    logic signed [13:0] r_breq;
    logic               r_flag;
    logic signed [13:0] r_steer;
    logic signed [15:0] r_fs;

    logic [14:0]        r_slewed;
    logic [12:0]        r_thr_lvl, r_brk_lvl;
    logic signed [13:0] r_steer_lvl;
    logic               r_hb;

    logic signed [17:0] r_err;
    logic [15:0]        r_cur;
    logic [14:0]        r_rem;
    logic [11:0]        r_q;
    logic               r_full;
    logic [3:0]         r_cnt;
    logic               r_pass;
    logic [12:0]        r_ratio1, r_scale, r_limited;

    // front stage
    logic signed [16:0] fs17, cur17;
    logic [15:0]        cur;
    logic [14:0]        range_eff, req, rate, slewed_nx, slewed_to;
    logic signed [17:0] err_pre, abs_err, head, div_a;
    logic               div_full;
    logic [14:0]        div_rem0;
    logic signed [13:0] steer_tgt, steer_nx, steer_zero;

    assign fs17  = {r_fs[15], r_fs};
    assign cur17 = r_fs[15] ? -fs17 : fs17;
    assign cur   = cur17[15:0];
    assign range_eff = (r_range_reg < MIN_RANGE) ? MIN_RANGE : r_range_reg;

    always_comb begin
        if (r_flag || r_ts[15]) begin
            req = '0;
        end else if (r_ts > $signed({1'b0, r_max_speed})) begin
            req = r_max_speed;
        end else begin
            req = r_ts[14:0];
        end
    end

    assign rate = (req <= r_slewed) ? r_decel : r_accel;
    assign slewed_nx = 15'(slew18($signed({3'b0, r_slewed}), $signed({3'b0, req}),
                                  $signed({3'b0, rate})));
    assign slewed_to = 15'(slew18($signed({3'b0, r_slewed}), 18'sd0,
                                  $signed({3'b0, r_decel})));
    assign err_pre = $signed({3'b0, slewed_nx}) - $signed({2'b0, cur});
    assign abs_err = err_pre[17] ? -err_pre : err_pre;
    assign head    = $signed({3'b0, r_max_speed}) - $signed({2'b0, r_cur});

    assign div_a    = (r_state == S_PRE) ? abs_err : head;
    assign div_full = (div_a > 18'sd0) && (div_a >= $signed({3'b0, range_eff}));
    assign div_rem0 = ((div_a > 18'sd0) && !div_full) ? div_a[14:0] : '0;

    always_comb begin
        if (r_steer > $signed({1'b0, QONE})) begin
            steer_tgt = $signed({1'b0, QONE});
        end else if (r_steer < -$signed({1'b0, QONE})) begin
            steer_tgt = -$signed({1'b0, QONE});
        end else begin
            steer_tgt = r_steer;
        end
    end

    assign steer_nx   = 14'(slew18(18'(r_steer_lvl), 18'(steer_tgt),
                                   $signed({5'b0, STEER_STEP})));
    assign steer_zero = 14'(slew18(18'(r_steer_lvl), 18'sd0,
                                   $signed({5'b0, STEER_STEP})));

    // shared divider step
    logic [15:0] rem2;
    logic        ge;
    logic [14:0] rem_nx;
    logic [11:0] q_nx;
    logic [12:0] div_res;

    assign rem2    = {r_rem, 1'b0};
    assign ge      = rem2 >= {1'b0, range_eff};
    assign rem_nx  = ge ? 15'(rem2 - {1'b0, range_eff}) : rem2[14:0];
    assign q_nx    = {r_q[10:0], ge};
    assign div_res = r_full ? QONE : {1'b0, q_nx};

    // multiply stage
    logic [12:0] thr;
    logic [25:0] prod;

    assign thr  = (r_err > 18'sd0) ? r_ratio1 : '0;
    assign prod = thr * r_scale;

    // brake and actuator stage
    logic [12:0] slb, sb, brk0, brk_f, m_over, brk_o, brk_sel, tb, tt;
    logic [12:0] thr_base, brk_base, thr_nx, brk_nx;
    logic signed [18:0] err_tol;
    logic        stop_full, over_on, overspd, back, hb_fin;

    assign slb = (r_limit_brake > QONE) ? QONE : r_limit_brake;
    assign sb  = (r_stop_brake > QONE) ? QONE : r_stop_brake;

    always_comb begin
        if (r_breq[13]) begin
            brk0 = '0;
        end else if (r_breq > $signed({1'b0, QONE})) begin
            brk0 = QONE;
        end else begin
            brk0 = r_breq[12:0];
        end
    end

    assign brk_f     = (sb > brk0) ? sb : brk0;
    assign stop_full = r_flag && (brk_f >= QONE);
    assign err_tol   = $signed({r_err[17], r_err}) + $signed({4'b0, r_tol});
    assign over_on   = !r_flag && err_tol[18];
    assign m_over    = (r_ratio1 < slb) ? r_ratio1 : slb;
    assign brk_o     = (m_over > brk0) ? m_over : brk0;
    assign brk_sel   = r_flag ? brk_f : (over_on ? brk_o : brk0);
    assign overspd   = {1'b0, r_cur} > ({2'b0, r_max_speed} + {2'b0, r_tol});
    assign tb        = (overspd && (slb > brk_sel)) ? slb : brk_sel;
    assign tt        = (tb != '0) ? '0 : r_limited;
    assign thr_base  = stop_full ? '0 : r_thr_lvl;
    assign brk_base  = stop_full ? brk_f : r_brk_lvl;
    assign thr_nx    = 13'(slew18($signed({5'b0, thr_base}), $signed({5'b0, tt}),
                                  $signed({5'b0, THROTTLE_STEP})));
    assign brk_nx    = 13'(slew18($signed({5'b0, brk_base}), $signed({5'b0, tb}),
                                  $signed({5'b0, BRAKE_STEP})));
    assign back      = r_fs < ROLLBACK_LIMIT;
    assign hb_fin    = (r_hb_on_brake && r_flag) || back || (tb >= QONE);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed   <= 15'd1000;
            r_range_reg   <= 15'd300;
            r_tol         <= 15'd50;
            r_limit_brake <= 13'd1024;
            r_stop_brake  <= 13'd4096;
            r_accel       <= 15'd20;
            r_decel       <= 15'd40;
            r_hb_on_brake <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_MAX_SPEED:      r_max_speed   <= i_cfg_data;
                REG_SLOWDOWN_RANGE: r_range_reg   <= i_cfg_data;
                REG_SPEED_TOL:      r_tol         <= i_cfg_data;
                REG_LIMIT_BRAKE:    r_limit_brake <= i_cfg_data[12:0];
                REG_STOP_BRAKE:     r_stop_brake  <= i_cfg_data[12:0];
                REG_ACCEL_STEP:     r_accel       <= i_cfg_data;
                REG_DECEL_STEP:     r_decel       <= i_cfg_data;
                REG_HB_ON_BRAKE:    r_hb_on_brake <= i_cfg_data[0];
                default:            r_hb_on_brake <= r_hb_on_brake;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slewed    <= '0;
            r_thr_lvl   <= '0;
            r_brk_lvl   <= '0;
            r_steer_lvl <= '0;
            r_hb        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_ts    <= i_target_speed;
                        r_breq  <= i_brake_request;
                        r_flag  <= i_brake_flag;
                        r_steer <= i_steer_request;
                        r_fs    <= i_forward_speed;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    unique case (t_cmd'(r_cmd))
                        CMD_MOVE: begin
                            if (r_fs < -GEAR_SWITCH_STOP_SPEED) begin
                                r_slewed    <= '0;
                                r_thr_lvl   <= '0;
                                r_brk_lvl   <= QONE;
                                r_steer_lvl <= steer_zero;
                                r_hb        <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_slewed <= slewed_nx;
                                r_err    <= err_pre;
                                r_cur    <= cur;
                                r_rem    <= div_rem0;
                                r_full   <= div_full;
                                r_q      <= '0;
                                r_cnt    <= 4'(DIV_BITS - 1);
                                r_pass   <= 1'b0;
                                r_state  <= S_DIV;
                            end
                        end
                        CMD_TIMEOUT: begin
                            r_slewed    <= slewed_to;
                            r_thr_lvl   <= '0;
                            r_brk_lvl   <= QONE;
                            r_steer_lvl <= steer_zero;
                            r_hb        <= 1'b1;
                            r_state     <= S_OUT;
                        end
                        default: begin
                            r_slewed    <= '0;
                            r_thr_lvl   <= '0;
                            r_brk_lvl   <= QONE;
                            r_steer_lvl <= '0;
                            r_hb        <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    endcase
                end
                S_DIV: begin
                    r_rem <= rem_nx;
                    r_q   <= q_nx;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == '0) begin
                        if (!r_pass) begin
                            // load headroom ratio on the same divider
                            r_ratio1 <= div_res;
                            r_rem    <= div_rem0;
                            r_full   <= div_full;
                            r_q      <= '0;
                            r_cnt    <= 4'(DIV_BITS - 1);
                            r_pass   <= 1'b1;
                        end else begin
                            r_scale <= div_res;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_limited <= prod[24:12];
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    r_thr_lvl   <= thr_nx;
                    r_brk_lvl   <= brk_nx;
                    r_steer_lvl <= steer_nx;
                    r_hb        <= hb_fin;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_throttle_out     = r_thr_lvl;
    assign o_brake_out        = r_brk_lvl;
    assign o_steering_out     = r_steer_lvl;
    assign o_handbrake_out    = r_hb;
    assign o_slewed_speed_out = r_slewed;

endmodule
